// ===== rtl/psfp_pkg.sv =====
// Package for the particulate sensor frame parser.
// Holds the transaction structs, configuration struct and protocol constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package psfp_pkg;

	// One input transaction: a received byte or a millisecond tick.
	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} psfp_in_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] pm_1_0;
		logic [15:0] pm_2_5;
		logic [15:0] pm_10_0;
		logic [15:0] temperature_tenths;
		logic [15:0] humidity_tenths;
		logic [15:0] formaldehyde;
		logic        warning;
	} psfp_out_t;

	// Configuration register contents.
	typedef struct packed {
		logic [1:0]  sensor_model;
		logic [15:0] timeout_ticks;
	} psfp_cfg_t;

	// Request types.
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_HEADER   = 2'd1;
	localparam logic [1:0] ST_LENGTH   = 2'd2;
	localparam logic [1:0] ST_CHECKSUM = 2'd3;

	// Sensor model codes.
	localparam logic [1:0] MODEL_BASIC = 2'd0;
	localparam logic [1:0] MODEL_TH    = 2'd1;
	localparam logic [1:0] MODEL_HCHO  = 2'd2;

	// Configuration port.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_MODEL  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd500;

	// Frame format.
	localparam logic [7:0]  HDR_0     = 8'h42;
	localparam logic [7:0]  HDR_1     = 8'h4D;
	localparam logic [15:0] LEN_SHORT = 16'd9;
	localparam logic [15:0] LEN_STD   = 16'd13;
	localparam logic [15:0] LEN_HCHO  = 16'd17;
	localparam int IDX_W          = 6;
	localparam int VIEW_DEPTH     = 64;
	localparam int TOTAL_W        = 7;
	localparam int FRAME_OVERHEAD = 6;
	localparam int POS_HDR_0      = 0;
	localparam int POS_HDR_1      = 1;
	localparam int POS_LEN_LO     = 3;

	// Byte offsets of the measurement words.
	localparam int POS_PM1     = 10;
	localparam int POS_PM25    = 12;
	localparam int POS_PM10    = 14;
	localparam int POS_TEMP_TH = 24;
	localparam int POS_HUM_TH  = 26;
	localparam int POS_HCHO    = 28;
	localparam int POS_TEMP_F  = 30;
	localparam int POS_HUM_F   = 32;

endpackage

`default_nettype wire

// ===== rtl/psfp_in_reg.sv =====
// Input register stage of the particulate sensor frame parser.
// Holds one accepted input transaction until the parse stage takes it.
// Depends on psfp_pkg.
`default_nettype none

module psfp_in_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire psfp_pkg::psfp_in_t in_data,
	input  wire logic             advance,
	output logic                  valid_s1,
	output psfp_pkg::psfp_in_t    item_s1
);
	import psfp_pkg::*;

	// The stage takes a new transaction when empty or when its content moves on.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/psfp_parse.sv =====
// Parse stage of the particulate sensor frame parser: frame state, frame
// bytes, running checksum, idle counter and result formation.
// Depends on psfp_pkg.
`default_nettype none

module psfp_parse #(
	parameter int FRAME_MAX = 40
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire psfp_pkg::psfp_in_t  item,
	input  wire psfp_pkg::psfp_cfg_t cfg,
	output logic                     res_valid,
	output psfp_pkg::psfp_out_t      res
);
	import psfp_pkg::*;

	logic [IDX_W-1:0]   byte_index_q;
	logic [15:0]        idle_count_q;
	logic [15:0]        running_sum_q;
	logic               warning_q;
	logic [7:0]         prev_byte_q;
	logic [TOTAL_W-1:0] total_q;

	logic [7:0]         view [VIEW_DEPTH];
	logic               is_byte;

	logic [IDX_W-1:0]   nxt_index;
	logic [15:0]        nxt_sum;
	logic [15:0]        nxt_idle;
	logic               nxt_warn;
	logic [TOTAL_W-1:0] nxt_total;
	logic [15:0]        idle_inc;
	logic [15:0]        len_word;
	logic               len_ok;
	logic [TOTAL_W-1:0] total_cand;
	logic [TOTAL_W-1:0] idx_ext;
	logic               fail;
	logic               done;
	logic [1:0]         code;

	assign is_byte = step && (item.req_type == REQ_BYTE);

	// Frame bytes, one register per position. The current byte is bypassed so
	// the final byte of a frame is seen by the result logic in the same cycle.
	for (genvar k = 0; k < VIEW_DEPTH; k++) begin : g_byte
		if (k < FRAME_MAX) begin : g_store
			logic [7:0] entry_q;

			always_ff @(posedge clk) begin
				if (is_byte && byte_index_q == IDX_W'(k)) begin
					entry_q <= item.rx_byte;
				end
			end

			assign view[k] = (byte_index_q == IDX_W'(k)) ? item.rx_byte : entry_q;
		end else begin : g_none
			assign view[k] = 8'h00;
		end
	end

	// Length check and frame size.
	always_comb begin
		len_word = {prev_byte_q, item.rx_byte};
		case (cfg.sensor_model)
			MODEL_BASIC: len_ok = (len_word == LEN_STD) || (len_word == LEN_SHORT);
			MODEL_TH:    len_ok = (len_word == LEN_STD);
			MODEL_HCHO:  len_ok = (len_word == LEN_HCHO);
			default:     len_ok = 1'b0;
		endcase
		total_cand = TOTAL_W'(FRAME_OVERHEAD) + {len_word[TOTAL_W-2:0], 1'b0};
	end

	// Next state for one transaction.
	always_comb begin
		nxt_index = byte_index_q;
		nxt_sum   = running_sum_q;
		nxt_idle  = idle_count_q;
		nxt_warn  = warning_q;
		nxt_total = total_q;
		fail      = 1'b0;
		done      = 1'b0;
		code      = ST_OK;
		idx_ext   = {1'b0, byte_index_q};
		idle_inc  = (idle_count_q == 16'hFFFF) ? idle_count_q : idle_count_q + 16'd1;

		if (item.req_type == REQ_TICK) begin
			// A long enough gap discards the partial frame.
			nxt_idle = idle_inc;
			if (idle_inc >= cfg.timeout_ticks) begin
				nxt_index = '0;
				nxt_sum   = '0;
			end
		end else begin
			nxt_idle = '0;
			if ((byte_index_q == IDX_W'(POS_HDR_0) && item.rx_byte != HDR_0) ||
			    (byte_index_q == IDX_W'(POS_HDR_1) && item.rx_byte != HDR_1)) begin
				fail = 1'b1;
				code = ST_HEADER;
			end else if (byte_index_q == IDX_W'(POS_LEN_LO) &&
			             !(len_ok && total_cand <= TOTAL_W'(FRAME_MAX))) begin
				fail = 1'b1;
				code = ST_LENGTH;
			end else if (byte_index_q <= IDX_W'(POS_LEN_LO)) begin
				nxt_sum   = running_sum_q + 16'(item.rx_byte);
				nxt_index = byte_index_q + IDX_W'(1);
				if (byte_index_q == IDX_W'(POS_LEN_LO)) begin
					nxt_total = total_cand;
				end
			end else if (idx_ext + TOTAL_W'(2) < total_q) begin
				nxt_sum   = running_sum_q + 16'(item.rx_byte);
				nxt_index = byte_index_q + IDX_W'(1);
			end else if (idx_ext + TOTAL_W'(1) < total_q) begin
				// First checksum byte is not summed.
				nxt_index = byte_index_q + IDX_W'(1);
			end else if (running_sum_q != len_word) begin
				fail = 1'b1;
				code = ST_CHECKSUM;
			end else begin
				done = 1'b1;
			end

			if (fail || done) begin
				nxt_index = '0;
				nxt_sum   = '0;
				nxt_warn  = fail;
			end
		end
	end

	// Result formation.
	always_comb begin
		res           = '0;
		res.status    = code;
		res.warning   = fail;
		if (done) begin
			case (cfg.sensor_model)
				MODEL_BASIC: begin
					res.pm_1_0  = {view[POS_PM1],  view[POS_PM1 + 1]};
					res.pm_2_5  = {view[POS_PM25], view[POS_PM25 + 1]};
					res.pm_10_0 = {view[POS_PM10], view[POS_PM10 + 1]};
				end
				MODEL_TH: begin
					res.pm_2_5             = {view[POS_PM25],    view[POS_PM25 + 1]};
					res.temperature_tenths = {view[POS_TEMP_TH], view[POS_TEMP_TH + 1]};
					res.humidity_tenths    = {view[POS_HUM_TH],  view[POS_HUM_TH + 1]};
				end
				default: begin
					res.pm_2_5             = {view[POS_PM25],   view[POS_PM25 + 1]};
					res.formaldehyde       = {view[POS_HCHO],   view[POS_HCHO + 1]};
					res.temperature_tenths = {view[POS_TEMP_F], view[POS_TEMP_F + 1]};
					res.humidity_tenths    = {view[POS_HUM_F],  view[POS_HUM_F + 1]};
				end
			endcase
		end
	end

	assign res_valid = is_byte && (fail || done);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			idle_count_q  <= '0;
			running_sum_q <= '0;
			warning_q     <= 1'b0;
		end else if (step) begin
			byte_index_q  <= nxt_index;
			idle_count_q  <= nxt_idle;
			running_sum_q <= nxt_sum;
			warning_q     <= nxt_warn;
		end
	end

	// Previous byte and frame size are only read within a frame.
	always_ff @(posedge clk) begin
		if (is_byte) begin
			prev_byte_q <= item.rx_byte;
			total_q     <= nxt_total;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/psfp_out_reg.sv =====
// Result register of the particulate sensor frame parser.
// Holds one result transaction until the receiver takes it.
// Depends on psfp_pkg.
`default_nettype none

module psfp_out_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                res_valid,
	input  wire psfp_pkg::psfp_out_t res,
	output logic                     can_take,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output psfp_pkg::psfp_out_t      out_data
);
	import psfp_pkg::*;

	logic      valid_s2;
	psfp_out_t result_s2;

	// The register can be loaded when empty or when its content leaves.
	assign can_take = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_take) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && res_valid) begin
			result_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

`default_nettype wire

// ===== rtl/particulate_sensor_frame_parser_unit.sv =====
// Particulate sensor frame parser, top level: configuration registers and
// the input register, parse stage and result register. Depends on psfp_pkg.
//
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one received UART
//   byte or one millisecond tick per transaction. The output channel
//   (out_valid, out_ready, out_data) carries one result transaction for each
//   completed frame and for each byte that breaks a frame. Ticks and bytes
//   inside a frame give no result.
//   A transaction accepted into the input register passes the parse logic
//   once the result register can take it and lands in the result register,
//   where a result raises out_valid. One transaction is accepted per cycle
//   while out_ready is high.
//   When the receiver stalls, the result register holds its transaction and
//   the input register still accepts one more; in_ready drops only when both
//   are full.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the
//   next clock edge. Reset selects the basic model, a timeout of 500 ticks,
//   clears the frame position, checksum, idle count and warning, and empties
//   both registers. No clearing pass is needed; the block is ready at once.
`default_nettype none

module particulate_sensor_frame_parser_unit #(
	parameter int FRAME_MAX = 40
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire psfp_pkg::psfp_in_t                   in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output psfp_pkg::psfp_out_t                       out_data,
	input  wire logic                                 cfg_we,
	input  wire logic [psfp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [psfp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import psfp_pkg::*;

	psfp_cfg_t cfg_q;
	logic      valid_s1;
	psfp_in_t  item_s1;
	logic      can_take;
	logic      step;
	logic      res_valid;
	psfp_out_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_model  <= MODEL_BASIC;
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SENSOR_MODEL:  cfg_q.sensor_model  <= cfg_wdata[1:0];
				CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The held transaction is processed when the result register can take it.
	assign step = valid_s1 && can_take;

	psfp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	psfp_parse #(
		.FRAME_MAX (FRAME_MAX)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	psfp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== rtl/psfp_checker.sv =====
// Port-level checker for the particulate sensor frame parser, bound to the
// top level. Depends on psfp_pkg.
`default_nettype none

module psfp_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire psfp_pkg::psfp_out_t out_data
);
	import psfp_pkg::*;

	// A stalled result transaction stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	// A stalled result transaction keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result payload changed while stalled");

	// The warning bit follows the status of the same result.
	a_warn_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.warning == (out_data.status != ST_OK)))
		else $error("warning does not match status");

	// An error result carries no measurement words.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
			out_data.pm_1_0 == 16'd0 && out_data.pm_2_5 == 16'd0 &&
			out_data.pm_10_0 == 16'd0 && out_data.temperature_tenths == 16'd0 &&
			out_data.humidity_tenths == 16'd0 && out_data.formaldehyde == 16'd0)
		else $error("error result carries measurement data");

endmodule

bind particulate_sensor_frame_parser_unit psfp_checker u_psfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ===== test/tb_particulate_sensor_frame_parser_unit.sv =====
// Testbench for particulate_sensor_frame_parser_unit: a table of directed bytes and ticks,
// then random sensor frames, checked against a frame predictor kept in this file.
// Depends on psfp_pkg and the parser RTL.
`default_nettype none

module tb_particulate_sensor_frame_parser_unit;
	import psfp_pkg::*;

	localparam int FRAME_BYTES     = 40;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int SETTLE_CYCLES   = 4;
	localparam int LONG_TICK_RUN   = 20;
	localparam logic [1:0] MODEL_UNUSED = 2'd3;

	localparam psfp_out_t NO_RESULT = '0;
	localparam psfp_out_t HDR_FAIL  =
		'{ST_HEADER, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
	localparam psfp_out_t LEN_FAIL  =
		'{ST_LENGTH, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1};

	// One directed transaction, with its result typed in where it is obvious.
	typedef struct packed {
		psfp_in_t  item;
		logic      typed;
		psfp_out_t res;
	} stim_row_t;

	localparam int N_ROWS = 20;
	stim_row_t directed_rows [N_ROWS] = '{
		'{'{REQ_TICK, 8'hFF}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'h00}, 1'b1, HDR_FAIL},
		'{'{REQ_BYTE, 8'hFF}, 1'b1, HDR_FAIL},
		'{'{REQ_BYTE, 8'h42}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'h42}, 1'b1, HDR_FAIL},
		'{'{REQ_BYTE, 8'h4D}, 1'b1, HDR_FAIL},
		'{'{REQ_BYTE, 8'h42}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'h4D}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'h00}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'h00}, 1'b1, LEN_FAIL},
		'{'{REQ_BYTE, 8'h42}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'h4D}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'hFF}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'hFF}, 1'b1, LEN_FAIL},
		'{'{REQ_BYTE, 8'h42}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'h4D}, 1'b0, NO_RESULT},
		'{'{REQ_TICK, 8'h00}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'h00}, 1'b0, NO_RESULT},
		'{'{REQ_BYTE, 8'h09}, 1'b0, NO_RESULT},
		'{'{REQ_TICK, 8'h55}, 1'b0, NO_RESULT}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid;
	logic                   in_ready;
	psfp_in_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	psfp_out_t              out_data;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Typed expectation travelling with the transaction on the input channel.
	logic      row_typed;
	psfp_out_t row_result;

	// Predictor copy of the parser state and configuration.
	logic [7:0]  frame_bytes [FRAME_BYTES];
	logic [5:0]  frame_pos;
	logic [15:0] idle_ticks;
	logic [15:0] byte_sum;
	logic [1:0]  model_sel;
	logic [15:0] timeout_limit;

	psfp_out_t pending_results [$];
	int        fail_count = 0;
	int        items_sent = 0;
	int        cycle_count = 0;
	bit        no_idle = 1'b0;
	bit        hold_off_req = 1'b0;

	particulate_sensor_frame_parser_unit #(
		.FRAME_MAX(FRAME_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("particulate_sensor_frame_parser_unit test failed");
			$finish;
		end
	end

	// Mostly no pause, sometimes a short one, now and then a long one.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] frame_word(input int pos);
		return {frame_bytes[pos], frame_bytes[pos + 1]};
	endfunction

	// Predicts the result, if any, of one accepted transaction and updates the state.
	task automatic advance_parser(input psfp_in_t it, output bit produced, output psfp_out_t res);
		int          pos;
		int          total;
		logic [15:0] len;
		bit          len_ok;
		produced = 1'b0;
		res = '0;
		if (it.req_type == REQ_TICK) begin
			if (idle_ticks != 16'hFFFF)
				idle_ticks = idle_ticks + 16'd1;
			if (idle_ticks >= timeout_limit) begin
				frame_pos = '0;
				byte_sum = '0;
			end
			return;
		end

		idle_ticks = '0;
		pos = int'(frame_pos);
		frame_bytes[pos] = it.rx_byte;
		len = frame_word(2);
		total = FRAME_OVERHEAD + 2 * int'(len);
		case (model_sel)
			MODEL_BASIC: len_ok = (len == LEN_SHORT) || (len == LEN_STD);
			MODEL_TH:    len_ok = (len == LEN_STD);
			MODEL_HCHO:  len_ok = (len == LEN_HCHO);
			default:     len_ok = 1'b0;
		endcase

		// Assume an error; the branches that keep collecting clear this.
		produced = 1'b1;
		res.warning = 1'b1;
		if ((pos == POS_HDR_0 && it.rx_byte != HDR_0) ||
				(pos == POS_HDR_1 && it.rx_byte != HDR_1)) begin
			res.status = ST_HEADER;
		end else if (pos == POS_LEN_LO && (!len_ok || total > FRAME_BYTES)) begin
			res.status = ST_LENGTH;
		end else if (pos <= POS_LEN_LO || pos + 2 < total) begin
			byte_sum = byte_sum + 16'(it.rx_byte);
			frame_pos = frame_pos + 6'd1;
			produced = 1'b0;
		end else if (pos + 1 < total) begin
			// First checksum byte: stored but not summed.
			frame_pos = frame_pos + 6'd1;
			produced = 1'b0;
		end else if (byte_sum != frame_word(total - 2)) begin
			res.status = ST_CHECKSUM;
		end else begin
			res.status = ST_OK;
			res.warning = 1'b0;
			res.pm_2_5 = frame_word(POS_PM25);
			case (model_sel)
				MODEL_BASIC: begin
					res.pm_1_0 = frame_word(POS_PM1);
					res.pm_10_0 = frame_word(POS_PM10);
				end
				MODEL_TH: begin
					res.temperature_tenths = frame_word(POS_TEMP_TH);
					res.humidity_tenths = frame_word(POS_HUM_TH);
				end
				default: begin
					res.formaldehyde = frame_word(POS_HCHO);
					res.temperature_tenths = frame_word(POS_TEMP_F);
					res.humidity_tenths = frame_word(POS_HUM_F);
				end
			endcase
		end
		if (produced) begin
			frame_pos = '0;
			byte_sum = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Compares each result transaction with the oldest expectation, then predicts
	// the input transaction accepted at the same edge.
	always @(posedge clk) begin : scoreboard
		psfp_out_t want;
		psfp_out_t predicted;
		bit        produced;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result expected none got %h", $time, out_data);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 16'(want.status), 16'(out_data.status));
					check_field("pm_1_0", want.pm_1_0, out_data.pm_1_0);
					check_field("pm_2_5", want.pm_2_5, out_data.pm_2_5);
					check_field("pm_10_0", want.pm_10_0, out_data.pm_10_0);
					check_field("temperature_tenths", want.temperature_tenths,
						out_data.temperature_tenths);
					check_field("humidity_tenths", want.humidity_tenths,
						out_data.humidity_tenths);
					check_field("formaldehyde", want.formaldehyde, out_data.formaldehyde);
					check_field("warning", 16'(want.warning), 16'(out_data.warning));
				end
			end
			if (in_valid && in_ready) begin
				advance_parser(in_data, produced, predicted);
				if (produced) begin
					pending_results.push_back(row_typed ? row_result : predicted);
				end else if (row_typed) begin
					$display("%0t: result expected %h got none predicted", $time, row_result);
					fail_count++;
				end
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off on request.
	initial begin : receiver
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				stall = no_idle ? 0 : pause_len();
				if (stall == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	// Offers one transaction after a random gap and waits until it is taken.
	task automatic send_item(input psfp_in_t it, input logic typed, input psfp_out_t expected);
		int gap;
		gap = no_idle ? 0 : pause_len();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		row_typed <= typed;
		row_result <= expected;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item('{REQ_BYTE, b}, 1'b0, NO_RESULT);
	endtask

	task automatic send_tick();
		send_item('{REQ_TICK, 8'($urandom)}, 1'b0, NO_RESULT);
	endtask

	// Stops offering and waits until every expected result has come out.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_SENSOR_MODEL)
			model_sel = data[1:0];
		else
			timeout_limit = data;
	endtask

	// Reconfigures only once the parser is idle; ticks and frame bytes give no
	// result, so the SETTLE_CYCLES wait covers what may still be in flight.
	task automatic configure(input logic [1:0] model, input logic [15:0] ticks);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(CFG_SENSOR_MODEL, {14'($urandom), model});
		write_reg(CFG_TIMEOUT_TICKS, ticks);
	endtask

	function automatic logic [15:0] valid_length();
		case (model_sel)
			MODEL_BASIC: return $urandom_range(0, 1) ? LEN_SHORT : LEN_STD;
			MODEL_TH:    return LEN_STD;
			MODEL_HCHO:  return LEN_HCHO;
			default:     return $urandom_range(0, 1) ? LEN_HCHO :
				($urandom_range(0, 1) ? LEN_SHORT : LEN_STD);
		endcase
	endfunction

	// Measurement words lean toward the extremes.
	function automatic logic [15:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// Builds a frame with random words and a trailing sum, optionally corrupted
	// or cut short, and sends it with the odd tick mixed in.
	task automatic send_sensor_frame(input logic [15:0] len_word, input bit bad_sum,
			input int cut);
		logic [7:0]  frame [$];
		logic [15:0] sum;
		logic [15:0] w;
		int          n_words;
		int          k;
		frame = {HDR_0, HDR_1, len_word[15:8], len_word[7:0]};
		n_words = (len_word > 16'd20) ? 20 : int'(len_word);
		for (k = 0; k < n_words; k++) begin
			w = rand_word();
			frame.push_back(w[15:8]);
			frame.push_back(w[7:0]);
		end
		sum = '0;
		for (k = 0; k < frame.size(); k++)
			sum = sum + 16'(frame[k]);
		if (bad_sum)
			sum = sum ^ (16'd1 << $urandom_range(0, 15));
		frame.push_back(sum[15:8]);
		frame.push_back(sum[7:0]);
		if (cut > 0) begin
			while (frame.size() > cut)
				void'(frame.pop_back());
		end
		for (k = 0; k < frame.size(); k++) begin
			if ($urandom_range(0, 32) == 0)
				send_tick();
			send_byte(frame[k]);
		end
	endtask

	// Random part of one configuration: mostly frames of valid length, some with a bad sum,
	// the rest truncated frames, bad lengths, line noise and idle ticks.
	task automatic run_random(input int n_items, input bit with_hold);
		int target;
		int sel;
		int cnt;
		int k;
		target = items_sent + n_items;
		if (with_hold) begin
			// Receiver holds off while bytes that break frames keep coming, so both
			// stages fill and the input stalls.
			hold_off_req = 1'b1;
			no_idle = 1'b1;
			for (k = 0; k < 48; k++)
				send_byte(8'($urandom_range(0, 8'h41)));
			no_idle = 1'b0;
		end
		while (items_sent < target) begin
			no_idle = ($urandom_range(0, 4) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 68) begin
				send_sensor_frame(valid_length(), $urandom_range(0, 6) == 0, 0);
			end else if (sel < 78) begin
				send_sensor_frame(valid_length(), 1'b0, $urandom_range(1, 23));
				cnt = (timeout_limit <= 16'd50) ? int'(timeout_limit) + 1 :
					$urandom_range(1, 3);
				repeat (cnt) send_tick();
			end else if (sel < 86) begin
				send_sensor_frame(16'($urandom), 1'b0, 0);
			end else if (sel < 95) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 6)) send_tick();
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin : stimulus
		int i;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		row_typed = 1'b0;
		row_result = '0;
		for (i = 0; i < FRAME_BYTES; i++)
			frame_bytes[i] = '0;
		frame_pos = '0;
		idle_ticks = '0;
		byte_sum = '0;
		model_sel = MODEL_BASIC;
		timeout_limit = TIMEOUT_RESET;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed table under the reset configuration.
		for (i = 0; i < N_ROWS; i++)
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);

		run_random(100, 1'b1);

		configure(MODEL_TH, 16'd1);
		run_random(100, 1'b1);

		// Longest timeout: a partial frame survives a run of ticks.
		configure(MODEL_HCHO, 16'hFFFF);
		run_random(60, 1'b0);
		send_byte(HDR_0);
		send_byte(HDR_1);
		send_byte(8'h00);
		no_idle = 1'b1;
		repeat (LONG_TICK_RUN) send_tick();
		no_idle = 1'b0;
		run_random(20, 1'b0);

		// Unused model code: every length is rejected.
		configure(MODEL_UNUSED, 16'd20);
		run_random(60, 1'b0);

		// Zero timeout: every tick drops a partial frame.
		configure(MODEL_BASIC, 16'd0);
		run_random(60, 1'b0);

		configure(MODEL_HCHO, 16'd3);
		run_random(60, 1'b0);

		configure(MODEL_TH, 16'd1200);
		run_random(60, 1'b0);

		drain();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("particulate_sensor_frame_parser_unit test passed");
		else
			$display("particulate_sensor_frame_parser_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/psfp_pkg.sv
rtl/psfp_in_reg.sv
rtl/psfp_parse.sv
rtl/psfp_out_reg.sv
rtl/particulate_sensor_frame_parser_unit.sv
rtl/psfp_checker.sv
test/tb_particulate_sensor_frame_parser_unit.sv
